FILE: src/thl_pkg.sv
package thl_pkg;

  // history size and derived widths
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam int unsigned TimeW = 64;
  localparam int unsigned PoseW = 64;
  localparam int unsigned TolW  = 20;

  localparam logic [TolW-1:0] TolReset = 20'd100;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_CLAMPED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] time_stamp;
    logic [PoseW-1:0] pose_word;
  } entry_t;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic load;    // shift towards the tail, new entry at the head
    logic rotate;  // shift towards the head, head wraps to the tail
  } cell_ctrl_t;

endpackage

FILE: src/thl_in_if.sv
interface thl_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] time_stamp;
  logic [63:0] pose_word;

  modport source (output valid, cmd, time_stamp, pose_word, input ready);
  modport sink   (input valid, cmd, time_stamp, pose_word, output ready);
endinterface

FILE: src/thl_out_if.sv
interface thl_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] found_time;
  logic [63:0] found_pose;
  logic [1:0]  status;

  modport source (output valid, found_time, found_pose, status, input ready);
  modport sink   (input valid, found_time, found_pose, status, output ready);
endinterface

FILE: src/thl_cell.sv
module thl_cell (
  input  logic               clk_i,
  input  thl_pkg::cell_ctrl_t ctrl_i,
  input  thl_pkg::entry_t    prev_i,
  input  thl_pkg::entry_t    next_i,
  output thl_pkg::entry_t    entry_o
);
  import thl_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= prev_i;
    end else if (ctrl_i.rotate) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;
endmodule

FILE: src/thl_chain.sv
module thl_chain (
  input  logic                clk_i,
  input  thl_pkg::cell_ctrl_t ctrl_i,
  input  thl_pkg::entry_t     new_entry_i,
  output thl_pkg::entry_t     head_o
);
  import thl_pkg::*;

  entry_t cell_q [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t prev_w;
    entry_t next_w;

    // head takes the new entry, tail takes the head on rotate
    if (i == 0) begin : g_head
      assign prev_w = new_entry_i;
    end else begin : g_body
      assign prev_w = cell_q[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_w = cell_q[0];
    end else begin : g_inner
      assign next_w = cell_q[i+1];
    end

    thl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (cell_q[i])
    );
  end

  assign head_o = cell_q[0];
endmodule

FILE: src/timestamped_history_lookup_core.sv
// add beat: taken only while idle, no result beat
// query beat: ST_WALK rotates the cell chain one full turn past its head comparator,
//   then ST_DONE loads the result once the output register is free (empty history: no walk)
// throughput: one add a cycle while idle, a new query only after the last result is loaded
// reset (async, active low): history empty, tolerance 100, cell contents undefined
module timestamped_history_lookup_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  thl_in_if.sink                    in_i,
  thl_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [thl_pkg::TolW-1:0]  cfg_wdata_i
);
  import thl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [TolW-1:0] tol_q;

  // fill level; outside a walk the newest entry sits in the head cell
  logic [CntW-1:0] count_q;

  // query context
  logic [TimeW-1:0] qts_q;
  logic [IdxW-1:0]  step_q;
  logic             found_q;
  entry_t           match_q;
  entry_t           oldest_q;

  // result register
  logic             out_valid_q;
  logic [TimeW-1:0] out_time_q;
  logic [PoseW-1:0] out_pose_q;
  status_e          out_status_q;

  cell_ctrl_t ctrl;
  entry_t     head;
  entry_t     new_entry;
  logic       in_beat;
  logic       add_beat;
  logic       query_beat;
  logic       step_in_fill;
  logic       step_is_oldest;
  logic       step_is_last;
  logic       oldest_later;
  logic [TimeW-1:0] oldest_gap;
  logic       clamp;
  logic       out_free;
  logic       emit;
  entry_t     res_entry;
  status_e    res_status;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign add_beat   = in_beat && (cmd_e'(in_i.cmd) == CMD_ADD);
  assign query_beat = in_beat && (cmd_e'(in_i.cmd) == CMD_QUERY);

  assign new_entry.time_stamp = in_i.time_stamp;
  assign new_entry.pose_word  = in_i.pose_word;

  // adds push the chain tailwards, a walk rotates it one full turn headwards
  assign ctrl.load   = add_beat;
  assign ctrl.rotate = (state_q == ST_WALK);

  thl_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .new_entry_i (new_entry),
    .head_o      (head)
  );

  // head cell holds the entry that is step_q places behind the newest
  assign step_in_fill   = CntW'(step_q) < count_q;
  assign step_is_oldest = CntW'(step_q) == (count_q - CntW'(1));
  assign step_is_last   = step_q == IdxW'(Depth - 1);

  // clamp test on the oldest entry, strict
  assign oldest_later = oldest_q.time_stamp > qts_q;
  assign oldest_gap   = oldest_q.time_stamp - qts_q;
  assign clamp        = oldest_later && (oldest_gap > TimeW'(tol_q));

  always_comb begin
    if (count_q == '0) begin
      res_status = STATUS_EMPTY;
      res_entry  = '0;
    end else if (clamp || !found_q) begin
      res_status = STATUS_CLAMPED;
      res_entry  = oldest_q;
    end else begin
      res_status = STATUS_FOUND;
      res_entry  = match_q;
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_beat) begin
          state_d = (count_q == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (step_is_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tol_q   <= TolReset;
      count_q <= '0;
      step_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      // fill level saturates once the ring is full
      if (add_beat && (count_q != CntW'(Depth))) begin
        count_q <= count_q + CntW'(1);
      end
      if (query_beat) begin
        step_q  <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_WALK) begin
        step_q <= step_q + IdxW'(1);
        // first entry, newest first, not later than the query
        if (!found_q && step_in_fill && (head.time_stamp <= qts_q)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // query payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (query_beat) begin
      qts_q <= in_i.time_stamp;
    end
    if (state_q == ST_WALK) begin
      if (!found_q && step_in_fill && (head.time_stamp <= qts_q)) begin
        match_q <= head;
      end
      if (step_is_oldest) begin
        oldest_q <= head;
      end
    end
  end

  // output register, a waiting result does not block further adds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_time_q   <= res_entry.time_stamp;
      out_pose_q   <= res_entry.pose_word;
      out_status_q <= res_status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found_time = out_time_q;
  assign out_o.found_pose = out_pose_q;
  assign out_o.status     = out_status_q;
endmodule

FILE: tb/tb.sv
module tb;
  import thl_pkg::*;

  // one input beat as it is queued for the driver
  typedef struct {
    cmd_e             cmd;
    logic [TimeW-1:0] time_stamp;
    logic [PoseW-1:0] pose_word;
    bit               drain_first;  // hold back until every lookup result is home
  } beat_t;

  // the result a query beat should bring back
  typedef struct {
    logic [TimeW-1:0] found_time;
    logic [PoseW-1:0] found_pose;
    status_e          status;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [TolW-1:0] cfg_wdata_i;

  thl_in_if  in_bus ();
  thl_out_if out_bus ();

  timestamped_history_lookup_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // beats still to be offered, lookup results still owed by the block
  beat_t   beats_to_send [$];
  lookup_t lookups_due [$];
  int unsigned mismatches = 0;

  // predictor copy of the history ring and the tolerance register
  logic [TimeW-1:0] hist_time [Depth];
  logic [PoseW-1:0] hist_pose [Depth];
  int unsigned      hist_newest = 0;
  int unsigned      hist_count  = 0;
  logic [TolW-1:0]  hist_tol    = TolReset;

  // stimulus side shadow: times of the last Depth adds, oldest first
  logic [TimeW-1:0] gen_recent [$];
  logic [TimeW-1:0] gen_cursor = 64'd3000;
  int unsigned      gen_tol    = TolReset;

  // long receiver hold-off, raised once by the sequencer
  logic long_hold = 1'b0;

  task automatic log_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // what the block should do with one accepted beat
  task automatic predict_lookup(input beat_t b);
    lookup_t     res;
    int unsigned oldest;
    int unsigned slot;
    bit          hit;
    if (b.cmd == CMD_ADD) begin
      // first add lands in slot 0, later ones push the newest pointer on
      if (hist_count != 0) hist_newest = (hist_newest + 1) % Depth;
      hist_time[hist_newest] = b.time_stamp;
      hist_pose[hist_newest] = b.pose_word;
      if (hist_count < Depth) hist_count++;
    end else begin
      if (hist_count == 0) begin
        res = '{found_time: '0, found_pose: '0, status: STATUS_EMPTY};
      end else begin
        // a part filled ring still has its oldest entry in slot 0
        oldest = (hist_count < Depth) ? 0 : (hist_newest + 1) % Depth;
        hit = 1'b0;
        // strict clamp: only when the oldest time is beyond the tolerance
        if (!(hist_time[oldest] > b.time_stamp &&
              hist_time[oldest] - b.time_stamp > {{(TimeW-TolW){1'b0}}, hist_tol})) begin
          slot = hist_newest;
          for (int n = 0; n < hist_count; n++) begin
            if (!hit && hist_time[slot] <= b.time_stamp) begin
              hit = 1'b1;
              res = '{found_time: hist_time[slot], found_pose: hist_pose[slot],
                      status: STATUS_FOUND};
            end
            slot = (slot + Depth - 1) % Depth;
          end
        end
        // clamped, or the walk came back empty handed
        if (!hit) begin
          res = '{found_time: hist_time[oldest], found_pose: hist_pose[oldest],
                  status: STATUS_CLAMPED};
        end
      end
      lookups_due.push_back(res);
    end
  endtask

  task automatic queue_beat(input cmd_e cmd, input logic [TimeW-1:0] ts,
                            input logic [PoseW-1:0] pose, input bit drain_first);
    beat_t b;
    b.cmd         = cmd;
    b.time_stamp  = ts;
    b.pose_word   = pose;
    b.drain_first = drain_first;
    beats_to_send.push_back(b);
    if (cmd == CMD_ADD) begin
      gen_recent.push_back(ts);
      if (gen_recent.size() > Depth) void'(gen_recent.pop_front());
    end
  endtask

  // mostly a rising time line with queries aimed around the stored entries,
  // plus out of order adds, extremes and plain noise
  task automatic queue_random_beat(input bit drain_first);
    logic [TimeW-1:0] ts;
    logic [TimeW-1:0] oldest;
    logic [TimeW-1:0] newest;
    cmd_e             cmd;
    oldest = gen_recent[0];
    newest = gen_recent[$];
    if ($urandom_range(0, 99) < 48) begin
      cmd = CMD_ADD;
      case ($urandom_range(0, 19))
        0: ts = {$urandom, $urandom};
        1: ts = newest;
        2: ts = newest - $urandom_range(1, 3000);
        3: begin
          gen_cursor = {$urandom, $urandom};
          ts = gen_cursor;
        end
        default: begin
          gen_cursor = gen_cursor + $urandom_range(1, 20000);
          ts = gen_cursor;
        end
      endcase
    end else begin
      cmd = CMD_QUERY;
      case ($urandom_range(0, 11))
        0: ts = {$urandom, $urandom};
        1: ts = '0;
        2: ts = '1;
        3: ts = oldest - gen_tol;
        4: ts = oldest - gen_tol - 1;
        5: ts = oldest - $urandom_range(0, gen_tol + 50);
        6: ts = newest + $urandom_range(0, 5000);
        default: ts = gen_recent[$urandom_range(0, gen_recent.size() - 1)]
                      + $urandom_range(0, 6) - 3;
      endcase
    end
    queue_beat(cmd, ts, {$urandom, $urandom}, drain_first);
  endtask

  // everything sent, every result home, then room for a trailing add
  task automatic await_idle();
    while (beats_to_send.size() != 0 || in_bus.valid || lookups_due.size() != 0)
      @(negedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [TolW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hist_tol = value;
    gen_tol  = value;
  endtask

  // input driver: bursts of beats separated by random gaps
  beat_t on_offer;
  bit    offer;
  int    burst_left = 1;
  int    gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid      <= 1'b0;
      in_bus.cmd        <= CMD_ADD;
      in_bus.time_stamp <= '0;
      in_bus.pose_word  <= '0;
    end else begin
      offer = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_lookup(on_offer);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (beats_to_send.size() != 0 &&
                     !(beats_to_send[0].drain_first && lookups_due.size() != 0)) begin
          on_offer = beats_to_send.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // about half the bursts run straight into the next one
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 9);
          end
        end
      end
      // valid stays high across back to back beats, one assignment a cycle
      in_bus.valid      <= offer;
      in_bus.cmd        <= on_offer.cmd;
      in_bus.time_stamp <= on_offer.time_stamp;
      in_bus.pose_word  <= on_offer.pose_word;
    end
  end

  // result monitor and receiver stalls
  lookup_t     want;
  logic [15:0] rx_ticks = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (lookups_due.size() == 0) begin
          log_mismatch("result beat with no query outstanding");
        end else begin
          want = lookups_due.pop_front();
          if (out_bus.found_time !== want.found_time)
            log_mismatch($sformatf("found_time %h, expected %h",
                                   out_bus.found_time, want.found_time));
          if (out_bus.found_pose !== want.found_pose)
            log_mismatch($sformatf("found_pose %h, expected %h",
                                   out_bus.found_pose, want.found_pose));
          if (out_bus.status !== want.status)
            log_mismatch($sformatf("status %0d, expected %s",
                                   out_bus.status, want.status.name()));
        end
      end
      rx_ticks++;
      // stretches of steady ready alternate with stretches of random stalls
      out_bus.ready <= !long_hold && (rx_ticks[8] || $urandom_range(0, 3) != 0);
    end
  end

  // sequencer: reset, directed beats, then random phases under new tolerances
  initial begin : sequencer
    int unsigned tol_plan [6];
    tol_plan = '{0, 20'hFFFFF, 1000000, 1, 0, 100};
    tol_plan[4] = $urandom_range(2, 20'hFFFFF);

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = TolReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    // empty history, both ends of the time range
    queue_beat(CMD_QUERY, '0, '0, 1'b0);
    queue_beat(CMD_QUERY, '1, '1, 1'b0);
    // single entry: exact hit, walk misses inside tolerance, clamp boundary
    queue_beat(CMD_ADD,   64'd1000, '1, 1'b0);
    queue_beat(CMD_QUERY, 64'd1000, '0, 1'b0);
    queue_beat(CMD_QUERY, 64'd999,  '0, 1'b0);
    queue_beat(CMD_QUERY, 64'd900,  '0, 1'b0);
    queue_beat(CMD_QUERY, 64'd899,  '1, 1'b0);
    queue_beat(CMD_QUERY, '0,       '0, 1'b0);
    // out of order adds, the walk takes the first match from the newest end
    queue_beat(CMD_ADD,   64'd2000, '0, 1'b0);
    queue_beat(CMD_ADD,   64'd1500, {$urandom, $urandom}, 1'b0);
    queue_beat(CMD_QUERY, 64'd1700, '0, 1'b0);
    queue_beat(CMD_QUERY, 64'd1499, '0, 1'b0);
    queue_beat(CMD_QUERY, '1,       '0, 1'b0);
    // extreme stored times
    queue_beat(CMD_ADD,   '1,       {$urandom, $urandom}, 1'b0);
    queue_beat(CMD_QUERY, '1,       '0, 1'b0);
    queue_beat(CMD_ADD,   '0,       {$urandom, $urandom}, 1'b0);
    queue_beat(CMD_QUERY, '0,       '0, 1'b0);
    queue_beat(CMD_QUERY, 64'd1,    '0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      await_idle();
      set_tolerance(TolW'(tol_plan[p]));
      @(negedge clk_i);
      // one phase has the sender wait for a full drain now and then
      for (int k = 0; k < 225; k++) queue_random_beat(p == 3 && k % 50 == 25);
      if (p == 2) begin
        // receiver holds off long enough for the block to back up its input
        @(posedge clk_i);
        long_hold <= 1'b1;
        repeat (900) @(posedge clk_i);
        long_hold <= 1'b0;
      end
    end
    await_idle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
